// File: rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helper functions for the NMEA sentence
// checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // Longest line that is still accepted, counting the newline.
    localparam int MAX_LINE_DEFAULT = 82;

    // Character codes of the framing.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;

    // Header length that decides the sentence kind.
    localparam logic [6:0] HEADER_LEN   = 7'd6;
    localparam logic [6:0] COUNT_SAT    = 7'd127;

    // Sentence kinds.
    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_FIX     = 2'd1;
    localparam logic [1:0] KIND_VIEW    = 2'd2;

    // Width of the packed result on the output stream.
    localparam int OUT_DATA_W = 24;

    // Line parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_BODY  = 6'b000010,
        PH_HEX1  = 6'b000100,
        PH_HEX2  = 6'b001000,
        PH_TAIL  = 6'b010000,
        PH_SKIP  = 6'b100000
    } phase_t;

    // Verdict for one line.
    typedef struct packed {
        logic [6:0] line_length;
        logic [7:0] computed_sum;
        logic [1:0] sentence_kind;
        logic       line_valid;
    } verdict_t;

    // Header byte of a position fix sentence ("$GPGGA") at a position.
    function automatic logic [7:0] hdr_fix_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h24;
            3'd1:    b = 8'h47;
            3'd2:    b = 8'h50;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h47;
            3'd5:    b = 8'h41;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Header byte of a satellites in view sentence ("$GPGSV") at a position.
    function automatic logic [7:0] hdr_view_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h24;
            3'd1:    b = 8'h47;
            3'd2:    b = 8'h50;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h53;
            3'd5:    b = 8'h56;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Uppercase hex digit decode: bit 4 is the good flag, bits 3:0 the value.
    // A byte that is not a digit decodes to value zero with the flag clear.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        else begin
            r = 5'b0_0000;
        end
        return r;
    endfunction

endpackage

// File: rtl/nmea_sentence_checker_unit.sv
// ----------------------------------------------------------------------------
// Latency: a newline byte passes through the input register, then the result
// register, before its verdict shows on m_tvalid.
// Throughput: one byte per cycle; a held verdict stalls only the next newline.
// Reset: rst_n clears the parser to start of line and empties both registers.
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit
// Checks NMEA 0183 lines from a byte stream and gives one verdict per line:
// framing, length and checksum good, sentence kind, computed XOR and length.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_unit
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] line_valid, [2:1] sentence_kind,
                                             // [10:3] computed_sum, [17:11] line_length
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       is_eol;
    logic       out_free;
    logic       advance;
    logic       out_load;
    verdict_t   verdict;

    // Input register handshake: a byte leaves when it is not a newline or
    // when the result register can take its verdict.
    assign is_eol   = (in_byte_reg == CHAR_NEWLINE);
    assign advance  = in_valid_reg && (!is_eol || out_free);
    assign out_load = advance && is_eol;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Line parser state.
    nsc_line_tracker #(
        .MAX_LINE (MAX_LINE)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .verdict (verdict)
    );

    // Result register.
    nsc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .verdict  (verdict),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A verdict is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_load && m_tvalid && !m_tready))
        else $error("verdict loaded over a waiting result");

    // The input side stalls only while a byte is held.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with nothing held");

    // A valid line is always longer than its header.
    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[17:11] > HEADER_LEN))
        else $error("valid verdict with short line");

    // Sentence kind never takes the unused code.
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:1] != 2'b11))
        else $error("unused sentence kind code");

endmodule

// File: rtl/nsc_line_tracker.sv
// ----------------------------------------------------------------------------
// nsc_line_tracker
// Per-line state of the checker. Each step takes one registered byte,
// updates the parser state and forms the verdict that a newline delivers.
// ----------------------------------------------------------------------------
module nsc_line_tracker
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output verdict_t   verdict
);

    localparam logic [6:0] MaxLen = 7'(MAX_LINE);

    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] rsum_reg, rsum_next;
    logic [6:0] count_reg, count_next;
    logic       fix_reg, fix_next;
    logic       view_reg, view_next;
    logic       err_reg, err_next;

    logic       err_now;
    logic       in_header;
    logic [4:0] hex;
    logic [6:0] len;

    // Verdict for a newline arriving in the current state.
    always_comb
    begin
        err_now = err_reg | (count_reg >= MaxLen);
        len     = (count_reg == COUNT_SAT) ? COUNT_SAT : 7'(count_reg + 7'd1);

        verdict.line_length  = len;
        verdict.computed_sum = xor_reg;
        verdict.sentence_kind = KIND_OTHER;
        if (count_reg >= HEADER_LEN) begin
            if (fix_reg) begin
                verdict.sentence_kind = KIND_FIX;
            end
            else if (view_reg) begin
                verdict.sentence_kind = KIND_VIEW;
            end
        end
        verdict.line_valid = (phase_reg == PH_TAIL) && !err_now &&
                             (rsum_reg == xor_reg) && (len > HEADER_LEN);
    end

    // Next state for one byte.
    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        rsum_next  = rsum_reg;
        count_next = count_reg;
        fix_next   = fix_reg;
        view_next  = view_reg;
        err_next   = err_now;
        in_header  = (count_reg < HEADER_LEN);
        hex        = hex_decode(rx_byte);

        if (rx_byte == CHAR_NEWLINE) begin
            // End of line: everything returns to its reset value.
            phase_next = PH_START;
            xor_next   = 8'h00;
            rsum_next  = 8'h00;
            count_next = 7'd0;
            fix_next   = 1'b1;
            view_next  = 1'b1;
            err_next   = 1'b0;
        end
        else begin
            // Header comparison against the two known sentence types.
            if (in_header && rx_byte != hdr_fix_byte(count_reg[2:0])) begin
                fix_next = 1'b0;
            end
            if (in_header && rx_byte != hdr_view_byte(count_reg[2:0])) begin
                view_next = 1'b0;
            end

            unique case (phase_reg)
                PH_START:
                begin
                    if (rx_byte == CHAR_DOLLAR) begin
                        phase_next = PH_BODY;
                    end
                    else begin
                        err_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_BODY:
                begin
                    if (rx_byte == CHAR_STAR) begin
                        phase_next = PH_HEX1;
                    end
                    else begin
                        xor_next = xor_reg ^ rx_byte;
                    end
                end
                PH_HEX1:
                begin
                    err_next   = err_now | ~hex[4];
                    rsum_next  = {rsum_reg[3:0], hex[3:0]};
                    phase_next = PH_HEX2;
                end
                PH_HEX2:
                begin
                    err_next   = err_now | ~hex[4];
                    rsum_next  = {rsum_reg[3:0], hex[3:0]};
                    phase_next = PH_TAIL;
                end
                PH_TAIL:
                begin
                    phase_next = PH_TAIL;
                end
                PH_SKIP:
                begin
                    phase_next = PH_SKIP;
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase

            if (count_reg != COUNT_SAT) begin
                count_next = 7'(count_reg + 7'd1);
            end
        end
    end

    // State registers, advanced once per byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_START;
            xor_reg   <= 8'h00;
            rsum_reg  <= 8'h00;
            count_reg <= 7'd0;
            fix_reg   <= 1'b1;
            view_reg  <= 1'b1;
            err_reg   <= 1'b0;
        end
        else if (step) begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            rsum_reg  <= rsum_next;
            count_reg <= count_next;
            fix_reg   <= fix_next;
            view_reg  <= view_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: rtl/nsc_out_reg.sv
// ----------------------------------------------------------------------------
// nsc_out_reg
// Result register of the checker. Holds one verdict until the downstream
// side takes the transfer, and packs it onto the output stream.
// ----------------------------------------------------------------------------
module nsc_out_reg
    import nsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  verdict_t              verdict,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic     valid_reg;
    verdict_t data_reg;

    // The register can take a verdict when empty or being drained.
    assign free = !valid_reg || m_tready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (load) begin
            valid_reg <= 1'b1;
        end
        else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Verdict payload.
    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= verdict;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(verdict_t)){1'b0}}, data_reg};

endmodule
